// File: rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// The expression must never be true.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

// File: rtl/smasm_pkg.sv
// Package with types, constants and codes of the small matrix add, subtract and multiply unit.
`timescale 1ns / 1ps
package smasm_pkg;

	localparam int ELEM_BITS     = 16;
	localparam int RES_BITS      = 33;
	localparam int OP_BITS       = 2;
	localparam int DIM_DEFAULT   = 3;
	localparam int DIM_MAX       = 8;
	localparam int ADDR_MAX_BITS = $clog2(DIM_MAX * DIM_MAX);

	localparam logic [OP_BITS-1:0] OP_ADD = 2'd0;
	localparam logic [OP_BITS-1:0] OP_SUB = 2'd1;
	localparam logic [OP_BITS-1:0] OP_MUL = 2'd2;

	typedef struct packed {
		logic signed [ELEM_BITS-1:0] a_element;
		logic signed [ELEM_BITS-1:0] b_element;
		logic                        final_pair;
	} in_item_t;

	typedef struct packed {
		logic signed [RES_BITS-1:0] result_element;
		logic                       result_last;
	} out_item_t;

	typedef struct packed {
		logic                     wr;
		logic [ADDR_MAX_BITS-1:0] wr_addr;
		logic                     rd;
		logic [ADDR_MAX_BITS-1:0] a_addr;
		logic [ADDR_MAX_BITS-1:0] b_addr;
		logic                     mul;
		logic                     sub;
		logic                     first;
		logic                     term_last;
		logic                     elem_last;
	} cmd_t;

	typedef struct packed {
		logic last_out;
	} status_t;

endpackage

// File: rtl/smasm_ctrl.sv
// Controller state machine that sequences loads and result computation.
`timescale 1ns / 1ps
module smasm_ctrl #(
	parameter int DIM = smasm_pkg::DIM_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          final_pair,
	input  logic                          wr_en,
	input  logic [smasm_pkg::OP_BITS-1:0] wr_data,
	input  smasm_pkg::status_t            sts,
	output logic                          busy,
	output smasm_pkg::cmd_t               cmd
);
	import smasm_pkg::*;

	localparam int CELLS = DIM * DIM;
	localparam int AW    = $clog2(CELLS);
	localparam int LW    = $clog2(CELLS + 1);
	localparam int DW    = $clog2(DIM);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t             state_q;
	logic [OP_BITS-1:0] op_q;
	logic [LW-1:0]      load_pos_q;
	logic [DW-1:0]      i_q;
	logic [DW-1:0]      j_q;
	logic [DW-1:0]      k_q;
	logic [AW-1:0]      a_addr_q;
	logic [AW-1:0]      b_addr_q;
	logic [AW-1:0]      row_base_q;

	logic accept;
	logic mul;
	logic k_done;
	logic j_done;
	logic i_done;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign mul    = (op_q & OP_MUL) != '0;
	assign k_done = !mul || (k_q == DW'(DIM - 1));
	assign j_done = (j_q == DW'(DIM - 1));
	assign i_done = (i_q == DW'(DIM - 1));

	always_comb begin
		cmd           = '0;
		cmd.wr        = accept && (load_pos_q < LW'(CELLS));
		cmd.wr_addr   = ADDR_MAX_BITS'(load_pos_q);
		cmd.rd        = (state_q == ST_RUN);
		cmd.a_addr    = ADDR_MAX_BITS'(a_addr_q);
		cmd.b_addr    = ADDR_MAX_BITS'(b_addr_q);
		cmd.mul       = mul;
		cmd.sub       = (op_q == OP_SUB);
		cmd.first     = !mul || (k_q == '0);
		cmd.term_last = k_done;
		cmd.elem_last = k_done && j_done && i_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_ADD;
		end else if (wr_en) begin
			op_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			load_pos_q <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			a_addr_q   <= '0;
			b_addr_q   <= '0;
			row_base_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (final_pair) begin
							load_pos_q <= '0;
							state_q    <= ST_RUN;
						end else if (load_pos_q < LW'(CELLS)) begin
							load_pos_q <= load_pos_q + LW'(1);
						end
					end
					i_q        <= '0;
					j_q        <= '0;
					k_q        <= '0;
					a_addr_q   <= '0;
					b_addr_q   <= '0;
					row_base_q <= '0;
				end
				ST_RUN: begin
					if (!k_done) begin
						k_q      <= k_q + DW'(1);
						a_addr_q <= a_addr_q + AW'(1);
						b_addr_q <= AW'(b_addr_q + AW'(DIM));
					end else begin
						k_q <= '0;
						if (!j_done) begin
							j_q <= j_q + DW'(1);
						end else begin
							j_q <= '0;
							i_q <= i_q + DW'(1);
						end
						if (!mul) begin
							a_addr_q <= a_addr_q + AW'(1);
							b_addr_q <= b_addr_q + AW'(1);
						end else if (!j_done) begin
							a_addr_q <= row_base_q;
							b_addr_q <= AW'(j_q) + AW'(1);
						end else begin
							row_base_q <= AW'(row_base_q + AW'(DIM));
							a_addr_q   <= AW'(row_base_q + AW'(DIM));
							b_addr_q   <= '0;
						end
						if (j_done && i_done) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (sts.last_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/smasm_dpath.sv
// Datapath with the two matrix stores and the shared multiply-accumulate unit.
`timescale 1ns / 1ps
module smasm_dpath #(
	parameter int DIM = smasm_pkg::DIM_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smasm_pkg::in_item_t  item,
	input  smasm_pkg::cmd_t      cmd,
	output smasm_pkg::status_t   sts,
	output smasm_pkg::out_item_t result,
	output logic                 strobe
);
	import smasm_pkg::*;

	localparam int CELLS = DIM * DIM;
	localparam int AW    = $clog2(CELLS);

	logic signed [ELEM_BITS-1:0] mem_a [CELLS];
	logic signed [ELEM_BITS-1:0] mem_b [CELLS];

	logic signed [ELEM_BITS-1:0]   a_s1;
	logic signed [ELEM_BITS-1:0]   b_s1;
	logic                          valid_s1;
	cmd_t                          cmd_s1;
	logic signed [2*ELEM_BITS-1:0] prod;
	logic signed [RES_BITS-1:0]    term;
	logic signed [RES_BITS-1:0]    term_s2;
	logic                          valid_s2;
	cmd_t                          cmd_s2;
	logic signed [RES_BITS-1:0]    acc_q;
	logic signed [RES_BITS-1:0]    sum;
	out_item_t                     result_q;
	logic                          strobe_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_a[cmd.wr_addr[AW-1:0]] <= item.a_element;
			mem_b[cmd.wr_addr[AW-1:0]] <= item.b_element;
		end
		if (cmd.rd) begin
			a_s1 <= mem_a[cmd.a_addr[AW-1:0]];
			b_s1 <= mem_b[cmd.b_addr[AW-1:0]];
		end
	end

	assign prod = a_s1 * b_s1;

	always_comb begin
		if (cmd_s1.mul) begin
			term = RES_BITS'(prod);
		end else if (cmd_s1.sub) begin
			term = RES_BITS'(a_s1) - RES_BITS'(b_s1);
		end else begin
			term = RES_BITS'(a_s1) + RES_BITS'(b_s1);
		end
	end

	assign sum = (cmd_s2.first ? RES_BITS'(0) : acc_q) + term_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd;
			valid_s2 <= valid_s1;
			strobe_q <= valid_s2 && cmd_s2.term_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			cmd_s1 <= cmd;
		end
		if (valid_s1) begin
			cmd_s2  <= cmd_s1;
			term_s2 <= term;
		end
		if (valid_s2) begin
			acc_q <= sum;
			if (cmd_s2.term_last) begin
				result_q.result_element <= sum;
				result_q.result_last    <= cmd_s2.elem_last;
			end
		end
	end

	assign sts.last_out = valid_s2 && cmd_s2.term_last && cmd_s2.elem_last;
	assign result       = result_q;
	assign strobe       = strobe_q;

endmodule

// File: rtl/small_matrix_add_sub_mul_unit.sv
// Each non-final transaction is a single load; busy stays low between loads.
// After the final transaction busy stays high until the last result has been registered.
// Sum and difference results then come one every cycle; each product result comes once the one
// shared multiply-accumulate unit has summed its DIM terms.
// Results are one-cycle strobes; the receiver cannot stall. Reset clears control and the
// operation register (to sum); the matrix stores are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module small_matrix_add_sub_mul_unit #(
	parameter int DIM = smasm_pkg::DIM_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  smasm_pkg::in_item_t           item,
	input  logic                          wr_en,
	input  logic [smasm_pkg::OP_BITS-1:0] wr_data,
	output smasm_pkg::out_item_t          result,
	output logic                          strobe
);
	import smasm_pkg::*;

	cmd_t    cmd;
	status_t sts;

	smasm_ctrl #(
		.DIM(DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.final_pair(item.final_pair),
		.wr_en     (wr_en),
		.wr_data   (wr_data),
		.sts       (sts),
		.busy      (busy),
		.cmd       (cmd)
	);

	smasm_dpath #(
		.DIM(DIM)
	) u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.sts   (sts),
		.result(result),
		.strobe(strobe)
	);

	`ASSERT_IMPLIES(a_strobe_after_busy, clk, arst_n, strobe, $past(busy))
	`ASSERT_NEXT(a_final_sets_busy, clk, arst_n, start && !busy && item.final_pair, busy)
	`ASSERT_NEVER(a_no_write_during_read, clk, arst_n, cmd.wr && cmd.rd)
	`ASSERT_NEXT(a_last_ends_burst, clk, arst_n, strobe && result.result_last, !strobe)

endmodule
